FILE: design/nfmt_pkg.sv
package nfmt_pkg;

  // default geometry of the table
  localparam int ENTRIES_DEF  = 16;
  localparam int SUBFLOWS_DEF = 4;

  // request opcodes
  localparam logic [1:0] OP_SET    = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_GET    = 2'd2;

  // response status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_CONFLICT = 3'd1;
  localparam logic [2:0] ST_DUP      = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_MISS     = 3'd4;
  localparam logic [2:0] ST_DISABLED = 3'd5;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [63:0] auth_key;
    logic [63:0] flow_id;
    logic [31:0] subflow_node;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] flow_out;
    logic        entry_freed;
  } rsp_t;

endpackage

FILE: design/nfmt_in_reg.sv
module nfmt_in_reg (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  nfmt_pkg::req_t  req_data,
  input  logic            advance,
  output logic            hold_valid,
  output nfmt_pkg::req_t  hold_item
);

  // hold only while the held beat cannot move on
  assign req_stall = hold_valid && !advance;

  // occupancy of the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (req_valid && !req_stall) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      hold_item <= req_data;
    end
  end

endmodule

FILE: design/nfmt_table.sv
module nfmt_table #(
  parameter int ENTRIES  = nfmt_pkg::ENTRIES_DEF,
  parameter int SUBFLOWS = nfmt_pkg::SUBFLOWS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            go,
  input  logic            set_enable,
  input  nfmt_pkg::req_t  item,
  output nfmt_pkg::rsp_t  result
);

  localparam int EIW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int SIW = (SUBFLOWS > 1) ? $clog2(SUBFLOWS) : 1;

  typedef struct packed {
    logic new_entry;
    logic add_sub;
    logic clr_sub;
    logic free_entry;
  } upd_t;

  // table storage
  logic [ENTRIES-1:0]               entry_valid;
  logic [63:0]                      entry_key  [ENTRIES];
  logic [63:0]                      entry_flow [ENTRIES];
  logic [ENTRIES-1:0][SUBFLOWS-1:0] sub_valid;
  logic [31:0]                      sub_id     [ENTRIES][SUBFLOWS];

  // search results
  logic [ENTRIES-1:0]               key_hit;
  logic [ENTRIES-1:0][SUBFLOWS-1:0] node_hit;
  logic                             hit_any;
  logic [EIW-1:0]                   hit_idx;
  logic                             free_any;
  logic [EIW-1:0]                   free_idx;
  logic [SUBFLOWS-1:0]              row_hit;
  logic [SUBFLOWS-1:0]              row_valid;
  logic                             sub_any;
  logic [SIW-1:0]                   sub_idx;
  logic                             slot_any;
  logic [SIW-1:0]                   slot_idx;
  logic [SUBFLOWS-1:0]              row_left;
  logic [63:0]                      hit_flow;
  upd_t                             upd;

  // parallel compare of every key and every subflow slot
  always_comb begin
    for (int e = 0; e < ENTRIES; e++) begin
      key_hit[e] = entry_valid[e] && (entry_key[e] == item.auth_key);
      for (int s = 0; s < SUBFLOWS; s++) begin
        node_hit[e][s] = sub_valid[e][s] && (sub_id[e][s] == item.subflow_node);
      end
    end
  end

  // lowest matching entry and lowest free entry
  always_comb begin
    hit_any  = 1'b0;
    hit_idx  = '0;
    free_any = 1'b0;
    free_idx = '0;
    for (int e = ENTRIES - 1; e >= 0; e--) begin
      if (key_hit[e]) begin
        hit_any = 1'b1;
        hit_idx = EIW'(e);
      end
      if (!entry_valid[e]) begin
        free_any = 1'b1;
        free_idx = EIW'(e);
      end
    end
  end

  assign row_hit   = node_hit[hit_idx];
  assign row_valid = sub_valid[hit_idx];
  assign hit_flow  = entry_flow[hit_idx];

  // lowest matching subflow and lowest free subflow slot in the hit row
  always_comb begin
    sub_any  = 1'b0;
    sub_idx  = '0;
    slot_any = 1'b0;
    slot_idx = '0;
    for (int s = SUBFLOWS - 1; s >= 0; s--) begin
      if (row_hit[s]) begin
        sub_any = 1'b1;
        sub_idx = SIW'(s);
      end
      if (!row_valid[s]) begin
        slot_any = 1'b1;
        slot_idx = SIW'(s);
      end
    end
  end

  // subflows still held once the matched one leaves
  always_comb begin
    row_left = row_valid;
    row_left[sub_idx] = 1'b0;
  end

  // request decode and status
  always_comb begin
    upd                = '0;
    result.status      = nfmt_pkg::ST_MISS;
    result.flow_out    = '0;
    result.entry_freed = 1'b0;
    case (item.opcode)
      nfmt_pkg::OP_SET: begin
        if (!set_enable) begin
          result.status = nfmt_pkg::ST_DISABLED;
        end else if (!hit_any) begin
          if (free_any) begin
            upd.new_entry = 1'b1;
            result.status = nfmt_pkg::ST_OK;
          end else begin
            result.status = nfmt_pkg::ST_FULL;
          end
        end else if (hit_flow != item.flow_id) begin
          result.status = nfmt_pkg::ST_CONFLICT;
        end else if (sub_any) begin
          result.status = nfmt_pkg::ST_DUP;
        end else if (slot_any) begin
          upd.add_sub   = 1'b1;
          result.status = nfmt_pkg::ST_OK;
        end else begin
          result.status = nfmt_pkg::ST_FULL;
        end
      end
      nfmt_pkg::OP_REMOVE: begin
        if (hit_any && sub_any) begin
          upd.clr_sub   = 1'b1;
          result.status = nfmt_pkg::ST_OK;
          if (row_left == '0) begin
            upd.free_entry     = 1'b1;
            result.entry_freed = 1'b1;
          end
        end
      end
      nfmt_pkg::OP_GET: begin
        if (hit_any && sub_any) begin
          result.status   = nfmt_pkg::ST_OK;
          result.flow_out = hit_flow;
        end
      end
      default: begin
        result.status = nfmt_pkg::ST_MISS;
      end
    endcase
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      sub_valid   <= '0;
    end else if (go) begin
      if (upd.new_entry) begin
        entry_valid[free_idx] <= 1'b1;
        sub_valid[free_idx]   <= SUBFLOWS'(1);
      end
      if (upd.add_sub) begin
        sub_valid[hit_idx][slot_idx] <= 1'b1;
      end
      if (upd.clr_sub) begin
        sub_valid[hit_idx][sub_idx] <= 1'b0;
      end
      if (upd.free_entry) begin
        entry_valid[hit_idx] <= 1'b0;
      end
    end
  end

  // keys, flows and subflow ids
  always_ff @(posedge clk) begin
    if (go && upd.new_entry) begin
      entry_key[free_idx]  <= item.auth_key;
      entry_flow[free_idx] <= item.flow_id;
      sub_id[free_idx][0]  <= item.subflow_node;
    end
    if (go && upd.add_sub) begin
      sub_id[hit_idx][slot_idx] <= item.subflow_node;
    end
  end

endmodule

FILE: design/nfmt_out_reg.sv
module nfmt_out_reg (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  nfmt_pkg::rsp_t  result,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output nfmt_pkg::rsp_t  rsp_data
);

  // occupancy of the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (load) begin
      rsp_data <= result;
    end
  end

endmodule

FILE: design/next_flow_map_table.sv
// a request beat waits in the input register and its response in the result register
// throughput: one request per cycle while no response beat is stalled
// the input register holds one beat and the result register one more
// reset (rst, synchronous, active high) empties both registers and every table entry,
// and sets set_enable to one
module next_flow_map_table #(
  parameter int ENTRIES  = nfmt_pkg::ENTRIES_DEF,
  parameter int SUBFLOWS = nfmt_pkg::SUBFLOWS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  nfmt_pkg::req_t  req_data,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output nfmt_pkg::rsp_t  rsp_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic            cfg_data
);

  logic            set_enable;
  logic            hold_valid;
  nfmt_pkg::req_t  hold_item;
  nfmt_pkg::rsp_t  result;
  logic            advance;

  // config register, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      set_enable <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      set_enable <= cfg_data;
    end
  end

  // held beat moves on when the result register is free or draining
  assign advance = hold_valid && (!rsp_valid || !rsp_stall);

  nfmt_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req_data   (req_data),
    .advance    (advance),
    .hold_valid (hold_valid),
    .hold_item  (hold_item)
  );

  nfmt_table #(
    .ENTRIES  (ENTRIES),
    .SUBFLOWS (SUBFLOWS)
  ) u_table (
    .clk        (clk),
    .rst        (rst),
    .go         (advance),
    .set_enable (set_enable),
    .item       (hold_item),
    .result     (result)
  );

  nfmt_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .result    (result),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
  );

endmodule

FILE: design/nfmt_checker.sv
module nfmt_checker (
  input logic            clk,
  input logic            rst,
  input logic            req_stall,
  input logic            rsp_valid,
  input logic            rsp_stall,
  input nfmt_pkg::rsp_t  rsp_data
);

  // a stalled response beat holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
    else $error("response beat changed while stalled");

  // request side stalls only when the response side is blocked
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> rsp_valid && rsp_stall)
    else $error("request stalled with response side free");

  // status stays within its defined codes
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_data.status == nfmt_pkg::ST_OK ||
                   rsp_data.status == nfmt_pkg::ST_CONFLICT ||
                   rsp_data.status == nfmt_pkg::ST_DUP ||
                   rsp_data.status == nfmt_pkg::ST_FULL ||
                   rsp_data.status == nfmt_pkg::ST_MISS ||
                   rsp_data.status == nfmt_pkg::ST_DISABLED))
    else $error("undefined status code");

  // flow id and freed flag only come with a successful request
  a_ok_only: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_data.flow_out != '0 || rsp_data.entry_freed) |->
      rsp_data.status == nfmt_pkg::ST_OK)
    else $error("flow or freed flag on a failed request");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !rsp_valid)
    else $error("response beat right after reset");

endmodule

bind next_flow_map_table nfmt_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp_data  (rsp_data)
);
